>>> sv/gld_pkg.sv
package gld_pkg;

  localparam logic [1:0] FuncByte  = 2'd0;
  localparam logic [1:0] FuncTick  = 2'd1;
  localparam logic [1:0] FuncStart = 2'd2;

  localparam logic [2:0] KindPixel    = 3'd0;
  localparam logic [2:0] KindEnd      = 3'd1;
  localparam logic [2:0] KindBadCode  = 3'd2;
  localparam logic [2:0] KindExhaust  = 3'd3;
  localparam logic [2:0] KindOverflow = 3'd4;

  localparam int unsigned CfgAddrW = 1;
  localparam logic [CfgAddrW-1:0] RegMinCodeSize = 1'b0;

endpackage

>>> sv/gld_ram.sv
module gld_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> sv/gif_lzw_decoder_unit.sv
// GIF LZW decoder. A byte or start transaction is handled as it is accepted, and any
// result adds an output state. A tick that pops the stack goes through accept, stack
// read and output. A decode tick walks the code's string in the table, pushing one
// pixel per cycle save a pause for a pending first pixel; the first code after a
// clear pushes its pixel with no walk. Results wait while m_axis_tready_i is low.
// Async active-low reset; the memories are not cleared; min_code_size resets to 8.
module gif_lzw_decoder_unit #(
  parameter int unsigned MAX_CODE_BITS = 12,
  parameter int unsigned ROOT_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [15:0]                 s_axis_tdata_i,  // func[1:0], data_byte[9:2]
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [15:0]                 m_axis_tdata_o,  // result_kind[2:0], pixel_index[10:3]
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [gld_pkg::CfgAddrW+1:0] paddr_i,
  input  logic [31:0]                 pwdata_i,
  output logic [31:0]                 prdata_o,
  output logic                        pready_o
);
  import gld_pkg::*;

  localparam int unsigned Tsz = 1 << MAX_CODE_BITS;
  localparam int unsigned Aw = MAX_CODE_BITS;
  localparam int unsigned Cw = MAX_CODE_BITS + 1;
  localparam int unsigned ResetMin = (ROOT_BITS < 8) ? ROOT_BITS : 8;

  typedef enum logic [2:0] {
    StIdle, StPop, StWalkRd, StWalk, StFirst, StOut
  } state_e;

  state_e      state_q;
  logic [3:0]  mcs_q;
  logic [Cw-1:0] depth_q;
  logic [31:0] buf_q;
  logic [5:0]  held_q;
  logic [3:0]  width_q;
  logic [Cw-1:0] nfc_q, prev_q, code_q, walk_q;
  logic [7:0]  left_q;
  logic        ended_q, done_q;
  logic [2:0]  kind_q;
  logic [7:0]  pix_q;
  logic [7:0]  k_q;
  logic        ovf_q;

  logic        wr_en;
  assign wr_en = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;
  assign prdata_o = {28'd0, mcs_q};

  logic [3:0] emin;
  logic [Cw-1:0] roots;
  always_comb begin
    emin = mcs_q;
    if (mcs_q < 4'd2) emin = 4'd2;
    if (mcs_q > 4'(ROOT_BITS)) emin = 4'(ROOT_BITS);
    roots = Cw'(1) << emin;
  end

  // memories
  logic          t_we, s_we;
  logic [Aw-1:0] t_waddr, t_raddr, s_waddr, s_raddr;
  logic [Aw-1:0] pre_wd, pre_rd;
  logic [7:0]    suf_wd, suf_rd, fst_wd, fst_rd, s_wd, s_rd;

  gld_ram #(.Width(Aw), .Depth(Tsz)) u_pre (.clk_i, .we_i(t_we), .waddr_i(t_waddr),
    .wdata_i(pre_wd), .raddr_i(t_raddr), .rdata_o(pre_rd));
  gld_ram #(.Width(8), .Depth(Tsz)) u_suf (.clk_i, .we_i(t_we), .waddr_i(t_waddr),
    .wdata_i(suf_wd), .raddr_i(t_raddr), .rdata_o(suf_rd));
  gld_ram #(.Width(8), .Depth(Tsz)) u_fst (.clk_i, .we_i(t_we), .waddr_i(t_waddr),
    .wdata_i(fst_wd), .raddr_i(t_raddr), .rdata_o(fst_rd));
  gld_ram #(.Width(8), .Depth(Tsz)) u_stk (.clk_i, .we_i(s_we), .waddr_i(s_waddr),
    .wdata_i(s_wd), .raddr_i(s_raddr), .rdata_o(s_rd));

  logic [1:0] func;
  logic [7:0] byte_in;
  assign func = s_axis_tdata_i[1:0];
  assign byte_in = s_axis_tdata_i[9:2];
  logic acc;
  assign s_axis_tready_o = (state_q == StIdle) && !ovf_q;
  assign acc = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (state_q == StOut);
  assign m_axis_tdata_o = {5'd0, pix_q, kind_q};

  logic [Cw-1:0] cur_code;
  assign cur_code = Cw'(buf_q & ((32'd1 << width_q) - 32'd1));

  // Stack pushes come from a pending first pixel or from the string walk.
  logic          push_v;
  logic [7:0]    push_d;
  logic          can_push;
  assign can_push = depth_q < Cw'(Tsz);
  always_comb begin
    push_v = 1'b0;
    push_d = 8'd0;
    t_we = 1'b0;
    t_waddr = nfc_q[Aw-1:0];
    pre_wd = prev_q[Aw-1:0];
    suf_wd = k_q;
    fst_wd = (prev_q < roots) ? prev_q[7:0] : fst_rd;
    t_raddr = walk_q[Aw-1:0];
    s_raddr = Aw'(depth_q - 1'b1);
    if (ovf_q) begin
      push_v = 1'b1;
      push_d = k_q;
    end else if (state_q == StWalk) begin
      push_v = 1'b1;
      if (walk_q >= roots + Cw'(2)) begin
        push_d = suf_rd;
        t_raddr = pre_rd;
      end else begin
        push_d = walk_q[7:0];
        t_raddr = prev_q[Aw-1:0];
      end
    end
    if (state_q == StFirst) begin
      t_we = nfc_q < Cw'(Tsz);
    end
    if (state_q == StIdle) t_raddr = prev_q[Aw-1:0];
  end
  assign s_we = push_v && can_push;
  assign s_waddr = depth_q[Aw-1:0];
  assign s_wd = push_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      mcs_q <= 4'd8;
      depth_q <= '0;
      buf_q <= '0;
      held_q <= '0;
      width_q <= 4'(ResetMin + 1);
      nfc_q <= Cw'((1 << ResetMin) + 2);
      prev_q <= Cw'(1 << ResetMin);
      code_q <= '0;
      walk_q <= '0;
      left_q <= '0;
      ended_q <= 1'b0;
      done_q <= 1'b0;
      kind_q <= KindPixel;
      pix_q <= '0;
      k_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      if (wr_en && paddr_i[CfgAddrW+1:2] == RegMinCodeSize) mcs_q <= pwdata_i[3:0];
      if (s_we) depth_q <= depth_q + 1'b1;
      case (state_q)
        StIdle: begin
          if (acc) begin
            case (func)
              FuncByte: begin
                if (!ended_q) begin
                  if (left_q == 8'd0) begin
                    if (byte_in == 8'd0) ended_q <= 1'b1;
                    else left_q <= byte_in;
                  end else begin
                    left_q <= left_q - 1'b1;
                    if (held_q > 6'd24) begin
                      kind_q <= KindOverflow;
                      pix_q <= 8'd0;
                      state_q <= StOut;
                    end else begin
                      buf_q <= buf_q | (32'(byte_in) << held_q);
                      held_q <= held_q + 6'd8;
                    end
                  end
                end
              end
              FuncTick: begin
                if (depth_q != '0) begin
                  depth_q <= depth_q - 1'b1;
                  state_q <= StPop;
                end else if (!done_q) begin
                  if (held_q < 6'(width_q)) begin
                    if (ended_q) begin
                      done_q <= 1'b1;
                      kind_q <= KindExhaust;
                      pix_q <= 8'd0;
                      state_q <= StOut;
                    end
                  end else begin
                    buf_q <= buf_q >> width_q;
                    held_q <= held_q - 6'(width_q);
                    if (cur_code == roots) begin
                      nfc_q <= roots + Cw'(2);
                      width_q <= emin + 4'd1;
                      prev_q <= roots;
                    end else if (cur_code == roots + Cw'(1)) begin
                      done_q <= 1'b1;
                      kind_q <= KindEnd;
                      pix_q <= 8'd0;
                      state_q <= StOut;
                    end else if (prev_q == roots) begin
                      if (cur_code >= roots) begin
                        done_q <= 1'b1;
                        kind_q <= KindBadCode;
                        pix_q <= 8'd0;
                        state_q <= StOut;
                      end else begin
                        ovf_q <= 1'b1;
                        k_q <= cur_code[7:0];
                        prev_q <= cur_code;
                      end
                    end else if (cur_code > nfc_q) begin
                      done_q <= 1'b1;
                      kind_q <= KindBadCode;
                      pix_q <= 8'd0;
                      state_q <= StOut;
                    end else begin
                      code_q <= cur_code;
                      walk_q <= (cur_code == nfc_q) ? prev_q : cur_code;
                      state_q <= StWalkRd;
                    end
                  end
                end
              end
              FuncStart: begin
                depth_q <= '0;
                buf_q <= '0;
                held_q <= '0;
                left_q <= '0;
                ended_q <= 1'b0;
                done_q <= 1'b0;
                nfc_q <= roots + Cw'(2);
                width_q <= emin + 4'd1;
                prev_q <= roots;
              end
              default: ;
            endcase
          end
        end
        StPop: begin
          kind_q <= KindPixel;
          pix_q <= s_rd;
          state_q <= StOut;
        end
        StWalkRd: begin
          // k = walk start if a root, else first_of(prev) read in idle; kwkwk pushes k first
          if (walk_q < roots) k_q <= walk_q[7:0];
          else k_q <= fst_rd;
          if (code_q == nfc_q) begin
            ovf_q <= 1'b1;
          end
          walk_q <= walk_q & Cw'(Tsz - 1);
          state_q <= StWalk;
        end
        StWalk: begin
          if (!ovf_q) begin
            if (walk_q >= roots + Cw'(2)) begin
              walk_q <= Cw'(pre_rd);
            end else begin
              k_q <= walk_q[7:0];
              walk_q <= prev_q;
              state_q <= StFirst;
            end
          end
        end
        StFirst: begin
          if (nfc_q < Cw'(Tsz)) begin
            nfc_q <= nfc_q + 1'b1;
            if (nfc_q + 1'b1 == (Cw'(1) << width_q) && width_q < 4'(MAX_CODE_BITS))
              width_q <= width_q + 4'd1;
          end
          prev_q <= code_q;
          state_q <= StIdle;
        end
        StOut: begin
          if (m_axis_tready_i) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
      if (ovf_q) begin
        ovf_q <= 1'b0;
      end
    end
  end

endmodule
